// ----- sv/tlf_pkg.sv -----
`default_nettype none
package tlf_pkg;

   // line geometry
   localparam int LINE_LEN    = 64;
   localparam int LINE_IDX_W  = $clog2(LINE_LEN);

   // front to back character queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // burst buffer: room for four held stop letters plus two converted characters;
   // a flush never meets a held plus, so one byte causes at most five
   localparam int BURST_MAX   = 6;
   localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

   localparam logic [15:0] LINE_LIMIT_RESET = 16'd50;

   // character codes
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // stop token length including the newline
   localparam logic [2:0] STOP_LEN = 3'd5;

   // one character moving between front, queue and back
   typedef struct packed {
      logic       vld;
      logic [7:0] data;
   } chr_type;

   // letters of the stop token by position
   function automatic logic [7:0] stop_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = CHAR_S;
         3'd1:    c = CHAR_T;
         3'd2:    c = CHAR_O;
         3'd3:    c = CHAR_P;
         default: c = CHAR_NL;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- sv/tlf_front.sv -----
`default_nettype none
module tlf_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire  [7:0]        req_tdata,
   output tlf_pkg::chr_type  push,
   input  wire               push_ready
);

   logic       at_start_ff, at_start_in;
   logic [2:0] match_ff, match_in;
   logic       plus_ff, plus_in;
   logic       stop_ff, stop_in;
   logic [7:0] pend_ff [tlf_pkg::BURST_MAX];
   logic [7:0] pend_in [tlf_pkg::BURST_MAX];
   logic [tlf_pkg::BURST_CNT_W-1:0] cnt_ff, cnt_in;

   logic push_fire;
   logic accept;

   assign push.vld   = (cnt_ff != '0);
   assign push.data  = pend_ff[0];
   assign push_fire  = push.vld && push_ready;
   assign req_tready = (cnt_ff == '0) ||
                       (cnt_ff == tlf_pkg::BURST_CNT_W'(1) && push_fire);
   assign accept     = req_tvalid && req_tready;

   // classify the byte and build its burst of characters
   always_comb begin
      logic [7:0] c;
      logic [7:0] conv0;
      logic [7:0] conv1;
      logic [1:0] conv_n;
      logic [2:0] flush_n;
      logic       do_conv;
      logic [2:0] rel;
      logic [2:0] pos;

      at_start_in = at_start_ff;
      match_in    = match_ff;
      plus_in     = plus_ff;
      stop_in     = stop_ff;
      cnt_in      = cnt_ff;
      for (int i = 0; i < tlf_pkg::BURST_MAX; i++) pend_in[i] = pend_ff[i];

      c       = (req_tdata == tlf_pkg::CHAR_NL) ? tlf_pkg::CHAR_SPACE : req_tdata;
      conv0   = c;
      conv1   = c;
      conv_n  = 2'd0;
      flush_n = 3'd0;
      do_conv = 1'b0;
      rel     = 3'd0;
      pos     = 3'd0;

      // drain one character to the queue
      if (push_fire) begin
         for (int i = 0; i < tlf_pkg::BURST_MAX - 1; i++) pend_in[i] = pend_ff[i + 1];
         cnt_in = cnt_ff - tlf_pkg::BURST_CNT_W'(1);
      end

      if (accept && !stop_ff) begin
         if (match_ff != 3'd0) begin
            if (req_tdata == tlf_pkg::stop_char(match_ff)) begin
               // token goes on; a full token halts
               if (match_ff + 3'd1 == tlf_pkg::STOP_LEN) begin
                  stop_in  = 1'b1;
                  match_in = 3'd0;
               end else begin
                  match_in = match_ff + 3'd1;
               end
            end else begin
               // failed match: release held letters, then the byte itself
               flush_n  = match_ff;
               match_in = 3'd0;
               do_conv  = 1'b1;
            end
         end else if (at_start_ff && req_tdata == tlf_pkg::CHAR_S) begin
            match_in    = 3'd1;
            at_start_in = 1'b0;
         end else begin
            do_conv = 1'b1;
         end

         if (do_conv) begin
            at_start_in = (req_tdata == tlf_pkg::CHAR_NL);
            if (c == tlf_pkg::CHAR_PLUS) begin
               if (plus_ff) begin
                  conv0   = tlf_pkg::CHAR_CARET;
                  conv_n  = 2'd1;
                  plus_in = 1'b0;
               end else begin
                  plus_in = 1'b1;
               end
            end else if (plus_ff) begin
               conv0   = tlf_pkg::CHAR_PLUS;
               conv1   = c;
               conv_n  = 2'd2;
               plus_in = 1'b0;
            end else begin
               conv0  = c;
               conv_n = 2'd1;
            end
         end

         // burst: held letters first, then converted characters
         for (int i = 0; i < tlf_pkg::BURST_MAX; i++) begin
            pos = 3'(i);
            rel = pos - flush_n;
            if (pos < flush_n) begin
               pend_in[i] = tlf_pkg::stop_char(pos);
            end else if (rel == 3'd0) begin
               pend_in[i] = conv0;
            end else begin
               pend_in[i] = conv1;
            end
         end
         cnt_in = tlf_pkg::BURST_CNT_W'(flush_n) + tlf_pkg::BURST_CNT_W'(conv_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         match_ff    <= 3'd0;
         plus_ff     <= 1'b0;
         stop_ff     <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         at_start_ff <= at_start_in;
         match_ff    <= match_in;
         plus_ff     <= plus_in;
         stop_ff     <= stop_in;
         cnt_ff      <= cnt_in;
      end
   end

   // burst payload, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < tlf_pkg::BURST_MAX; i++) pend_ff[i] <= pend_in[i];
   end

endmodule
`default_nettype wire

// ----- sv/tlf_queue.sv -----
`default_nettype none
module tlf_queue (
   input  wire               clock,
   input  wire               reset,
   input  tlf_pkg::chr_type  push,
   output logic              push_ready,
   output tlf_pkg::chr_type  head,
   input  wire               pop
);

   localparam int CNT_W = $clog2(tlf_pkg::QUEUE_DEPTH + 1);

   logic [7:0] slot_ff [tlf_pkg::QUEUE_DEPTH];
   logic [tlf_pkg::QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [tlf_pkg::QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (cnt_ff != CNT_W'(tlf_pkg::QUEUE_DEPTH));
   assign head.vld   = (cnt_ff != '0);
   assign head.data  = slot_ff[rd_ff];
   assign do_push    = push.vld && push_ready;
   assign do_pop     = pop && head.vld;

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == tlf_pkg::QUEUE_PTR_W'(tlf_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ff + tlf_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == tlf_pkg::QUEUE_PTR_W'(tlf_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ff + tlf_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push.data;
      end
   end

endmodule
`default_nettype wire

// ----- sv/tlf_back.sv -----
`default_nettype none
module tlf_back (
   input  wire               clock,
   input  wire               reset,
   input  tlf_pkg::chr_type  head,
   output logic              pop,
   input  wire  [15:0]       line_limit,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   localparam int IW = tlf_pkg::LINE_IDX_W;

   typedef enum logic [1:0] {
      BK_FILL = 2'b01,
      BK_EMIT = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [7:0]    line_mem [tlf_pkg::LINE_LEN];
   logic [IW-1:0] col_ff, col_in;
   logic [IW-1:0] rd_ff, rd_in;
   logic [15:0]   lines_ff, lines_in;
   logic          halt_ff, halt_in;

   // read stage and output register
   logic       rdv_ff, rdv_in;
   logic [7:0] rdata_ff;
   logic       rlast_ff;
   logic       ov_ff, ov_in;
   logic [7:0] ochar_ff;
   logic       olast_ff;

   logic wr_en;
   logic issue;
   logic load_out;
   logic [15:0] lines_inc;

   assign pop       = (state_ff == BK_FILL) && head.vld;
   assign wr_en     = pop && !halt_ff;
   assign load_out  = rdv_ff && (!ov_ff || rsp_tready);
   assign issue     = (state_ff == BK_EMIT) && (!rdv_ff || load_out);
   assign lines_inc = lines_ff + 16'd1;

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ochar_ff;
   assign rsp_tlast  = olast_ff;

   // fill the line, then read it out
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      rd_in    = rd_ff;
      lines_in = lines_ff;
      halt_in  = halt_ff;
      case (state_ff)
         BK_FILL: begin
            if (wr_en) begin
               if (col_ff == IW'(tlf_pkg::LINE_LEN - 1)) begin
                  col_in   = '0;
                  rd_in    = '0;
                  lines_in = lines_inc;
                  halt_in  = (lines_inc >= line_limit);
                  state_in = BK_EMIT;
               end else begin
                  col_in = col_ff + IW'(1);
               end
            end
         end
         BK_EMIT: begin
            if (issue) begin
               rd_in = rd_ff + IW'(1);
               if (rd_ff == IW'(tlf_pkg::LINE_LEN - 1)) begin
                  rd_in    = '0;
                  state_in = BK_FILL;
               end
            end
         end
         default: begin
            state_in = BK_FILL;
         end
      endcase

      rdv_in = issue ? 1'b1 : (load_out ? 1'b0 : rdv_ff);
      ov_in  = load_out ? 1'b1 : (rsp_tready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FILL;
         col_ff   <= '0;
         rd_ff    <= '0;
         lines_ff <= 16'd0;
         halt_ff  <= 1'b0;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         rd_ff    <= rd_in;
         lines_ff <= lines_in;
         halt_ff  <= halt_in;
         rdv_ff   <= rdv_in;
         ov_ff    <= ov_in;
      end
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[col_ff] <= head.data;
      end
      if (issue) begin
         rdata_ff <= line_mem[rd_ff];
         rlast_ff <= (rd_ff == IW'(tlf_pkg::LINE_LEN - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         ochar_ff <= rdata_ff;
         olast_ff <= rlast_ff;
      end
   end

endmodule
`default_nettype wire

// ----- sv/text_line_folder_with_stop_core.sv -----
`default_nettype none
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tdata[7:0] in_char
// rsp      out        rsp_tvalid/rsp_tready   tdata[7:0] out_char, tlast line_end
// csr      in         csr_valid/csr_ready     wdata[15:0] line_limit
//
// The front takes one byte per cycle if it causes at most one character and
// the queue has room; a longer burst (up to five) drains before the next byte.
// The back writes one character per cycle into the line store while the queue
// has any, then streams the line out one per cycle while rsp_tready is high.
// Synchronous active-high reset; the line store needs no clearing pass.
// A stalled rsp side backs up through the character queue to req_tready.
module text_line_folder_with_stop_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_char
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast,   // line_end
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_wdata    // [15:0] line_limit
);

   logic [15:0] line_limit_ff;
   tlf_pkg::chr_type push;
   tlf_pkg::chr_type head;
   logic push_ready;
   logic pop;

   // line limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= tlf_pkg::LINE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         line_limit_ff <= csr_wdata;
      end
   end

   tlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_ready (push_ready)
   );

   tlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   tlf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .line_limit (line_limit_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- bench/text_line_folder_with_stop_core_tb.sv -----
module text_line_folder_with_stop_core_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int OPEN_N        = 27;

   // one character of a finished line as it should leave the block
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } line_char_type;

   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_type;

   // Folds accepted bytes into lines and holds the characters still owed by the block
   class folded_line_board_type;
      logic [15:0]   line_limit;
      bit            at_start;
      int            match_len;
      bit            plus_held;
      logic [7:0]    line_buf [tlf_pkg::LINE_LEN];
      int            column;
      logic [15:0]   lines_done;
      bit            halted;
      logic [7:0]    token [5];
      line_char_type owed_chars [$];
      int            errors;
      int            bytes_seen;
      int            chars_seen;
      int            lines_seen;

      function new();
         token      = '{tlf_pkg::CHAR_S, tlf_pkg::CHAR_T, tlf_pkg::CHAR_O,
                        tlf_pkg::CHAR_P, tlf_pkg::CHAR_NL};
         line_limit = tlf_pkg::LINE_LIMIT_RESET;
         at_start   = 1;
         match_len  = 0;
         plus_held  = 0;
         column     = 0;
         lines_done = 0;
         halted     = 0;
         errors     = 0;
         bytes_seen = 0;
         chars_seen = 0;
         lines_seen = 0;
      endfunction

      // store one character; a full line is owed as a whole
      function void push_char(logic [7:0] c);
         int k;
         line_char_type item;
         if (halted) return;
         line_buf[column] = c;
         column++;
         if (column == tlf_pkg::LINE_LEN) begin
            for (k = 0; k < tlf_pkg::LINE_LEN; k++) begin
               item.ch   = line_buf[k];
               item.last = (k == tlf_pkg::LINE_LEN - 1);
               owed_chars.push_back(item);
            end
            column = 0;
            lines_done++;
            if (lines_done >= line_limit) halted = 1;
         end
      endfunction

      // newline to space, then '+' pairing
      function void fold_byte(logic [7:0] b);
         logic [7:0] c;
         c = (b == tlf_pkg::CHAR_NL) ? tlf_pkg::CHAR_SPACE : b;
         if (halted) return;
         if (c == tlf_pkg::CHAR_PLUS) begin
            if (plus_held) begin
               plus_held = 0;
               push_char(tlf_pkg::CHAR_CARET);
            end else begin
               plus_held = 1;
            end
         end else begin
            if (plus_held) begin
               plus_held = 0;
               push_char(tlf_pkg::CHAR_PLUS);
            end
            push_char(c);
         end
      endfunction

      // accepted input transaction
      function void take_byte(logic [7:0] b);
         int k;
         bytes_seen++;
         if (halted) return;
         if (match_len > 0) begin
            if (b == token[match_len]) begin
               match_len++;
               if (match_len == 5) begin
                  halted    = 1;
                  match_len = 0;
               end
               return;
            end
            // stop match broke: held letters go out first
            for (k = 0; k < match_len; k++)
               fold_byte(token[k]);
            match_len = 0;
         end else if (at_start && b == tlf_pkg::CHAR_S) begin
            match_len = 1;
            at_start  = 0;
            return;
         end
         fold_byte(b);
         at_start = (b == tlf_pkg::CHAR_NL);
      endfunction

      // accepted output transaction against the oldest owed character
      function void match_char(logic [7:0] ch, logic last);
         line_char_type want;
         if (owed_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected character: expected none, actual %h (last %b)",
                     $time, ch, last);
            return;
         end
         want = owed_chars.pop_front();
         chars_seen++;
         if (last) lines_seen++;
         if (ch !== want.ch) begin
            errors++;
            $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, ch);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: line_end mismatch: expected %b, actual %b", $time, want.last, last);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;
   wire         rsp_tlast;
   logic        csr_valid  = 1'b0;
   wire         csr_ready;
   logic [15:0] csr_wdata  = 16'h0000;

   folded_line_board_type board = new();

   int          cycles       = 0;
   int          burst_left   = 0;
   int          csr_writes   = 0;
   rx_mode_type rx_mode      = RX_OPEN;
   int          rx_mode_left = 0;
   int          rx_run_left  = 0;
   bit          rx_run_ready = 1'b1;

   // opening text: each broken stop prefix, extremes of the byte, '+' pairing
   logic [7:0] opening_text [OPEN_N] = '{
      // lone S flushed
      tlf_pkg::CHAR_S, "x", tlf_pkg::CHAR_NL,
      // ST flushed, zero byte
      tlf_pkg::CHAR_S, tlf_pkg::CHAR_T, 8'h00, tlf_pkg::CHAR_NL,
      // STO flushed by newline
      tlf_pkg::CHAR_S, tlf_pkg::CHAR_T, tlf_pkg::CHAR_O, tlf_pkg::CHAR_NL,
      // STOP flushed, all-ones byte
      tlf_pkg::CHAR_S, tlf_pkg::CHAR_T, tlf_pkg::CHAR_O, tlf_pkg::CHAR_P, 8'hFF,
      // S mid-line is plain text
      "a", tlf_pkg::CHAR_S,
      // pair, then a lone plus
      tlf_pkg::CHAR_PLUS, tlf_pkg::CHAR_PLUS, tlf_pkg::CHAR_PLUS, 8'h80,
      // plus released by newline
      tlf_pkg::CHAR_PLUS, tlf_pkg::CHAR_NL,
      // S flushed by a plus pair
      tlf_pkg::CHAR_S, tlf_pkg::CHAR_PLUS, tlf_pkg::CHAR_PLUS
   };

   text_line_folder_with_stop_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles", $time, cycles);
         $display("text_line_folder_with_stop_core_tb: done, errors");
         $finish;
      end
   end

   // receiver: check each output transaction, stall in changing modes
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.match_char(rsp_tdata, rsp_tlast);
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(40, 300);
      end
      rx_mode_left--;
      case (rx_mode)
         RX_OPEN:  rsp_tready <= 1'b1;
         RX_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (rx_run_left == 0) begin
               rx_run_ready = !rx_run_ready;
               rx_run_left  = $urandom_range(1, 40);
            end
            rx_run_left--;
            rsp_tready <= rx_run_ready;
         end
      endcase
   end

   // one input transaction; bursts of random length with random gaps
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.take_byte(b);
   endtask

   // random text must not finish a stop token by chance
   task automatic send_safe(input logic [7:0] b);
      if (board.match_len == 4 && b == tlf_pkg::CHAR_NL) b = tlf_pkg::CHAR_SPACE;
      send_byte(b);
   endtask

   // hold the sender until every owed character is out, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (board.owed_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_limit(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.line_limit = v;
      csr_writes++;
   endtask

   // mostly text-like input: letters, newlines, plus runs, broken stop prefixes
   task automatic send_text(input int count);
      int stop_at;
      int kind;
      int n;
      int k;
      stop_at = board.bytes_seen + count;
      while (board.bytes_seen < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            send_safe(8'($urandom_range(8'h20, 8'h7E)));
         end else if (kind < 55) begin
            send_safe(tlf_pkg::CHAR_NL);
         end else if (kind < 70) begin
            send_safe(tlf_pkg::CHAR_PLUS);
            if ($urandom_range(0, 1)) send_safe(tlf_pkg::CHAR_PLUS);
         end else if (kind < 82) begin
            if (!board.at_start && board.match_len == 0) send_safe(tlf_pkg::CHAR_NL);
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
               send_safe(board.token[k]);
            send_safe(8'($urandom_range(0, 255)));
         end else begin
            send_safe(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      int    i;
      string ending;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opening at the reset line limit
      for (i = 0; i < OPEN_N; i++)
         send_byte(opening_text[i]);
      drain();

      // no practical limit
      write_line_limit(16'hFFFF);
      send_text(40);
      drain();

      // limit a few lines ahead
      write_line_limit(16'(board.lines_done + $urandom_range(6, 20)));
      send_text(40);
      drain();

      // limit of one: the next full line halts
      write_line_limit(16'd1);
      if ($urandom_range(0, 1)) begin
         ending = "line limit inside a flush";
         while (!board.halted &&
                (board.column != tlf_pkg::LINE_LEN - 2 ||
                 board.plus_held || board.match_len != 0))
            send_byte("a");
         // line completes on the flushed S; T and x are dropped
         if (!board.halted) begin
            send_byte(tlf_pkg::CHAR_NL);
            send_byte(tlf_pkg::CHAR_S);
            send_byte(tlf_pkg::CHAR_T);
            send_byte("x");
         end
      end else begin
         ending = "stop token";
         if (!board.at_start || board.match_len != 0) send_byte(tlf_pkg::CHAR_NL);
         if (!board.halted) begin
            for (i = 0; i < 5; i++)
               send_byte(board.token[i]);
         end
      end

      // ignored once halted
      for (i = 0; i < 8; i++)
         send_byte(8'($urandom_range(0, 255)));
      drain();

      $display("run: %0d input bytes, %0d characters in %0d lines checked, %0d limit writes",
               board.bytes_seen, board.chars_seen, board.lines_seen, csr_writes);
      $display("run: ended by %s, halted %0b", ending, board.halted);
      if (board.errors == 0) begin
         $display("text_line_folder_with_stop_core_tb: done, clean");
      end else begin
         $display("text_line_folder_with_stop_core_tb: done, errors");
      end
      $finish;
   end

endmodule
